FILE: rtl/mibf_pkg.sv
// Shared types and constants of the MAC/IP binding filter.
`timescale 1ns / 1ps

package mibf_pkg;

    // Field widths of the request and result words.
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned ETYPE_W    = 16;
    localparam int unsigned MAC_W      = 48;
    localparam int unsigned IP_W       = 32;
    localparam int unsigned PROTO_W    = 8;
    localparam int unsigned IHL_W      = 4;
    localparam int unsigned CAUSE_W    = 4;
    localparam int unsigned S_TDATA_W  = 208;
    localparam int unsigned M_TDATA_W  = 8;

    // One table entry is valid bit, MAC and IP.
    localparam int unsigned ENTRY_W    = 1 + MAC_W + IP_W;

    localparam logic [LEN_W-1:0]   ETH_HDR_BYTES  = 16'd14;
    localparam logic [LEN_W-1:0]   IP_HDR_BYTES   = 16'd20;
    localparam logic [LEN_W-1:0]   TCP_HDR_BYTES  = 16'd20;
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;

    typedef enum logic [REQ_W-1:0] {
        REQ_CHECK  = 2'd0,
        REQ_BIND   = 2'd1,
        REQ_UNBIND = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_OK        = 4'd0,
        CAUSE_SHORT_ETH = 4'd1,
        CAUSE_NOT_IPV4  = 4'd2,
        CAUSE_SHORT_IP  = 4'd3,
        CAUSE_UNKNOWN   = 4'd4,
        CAUSE_MISMATCH  = 4'd5,
        CAUSE_SHORT_TCP = 4'd6,
        CAUSE_BOUND     = 4'd7,
        CAUSE_FULL      = 4'd8,
        CAUSE_UNBOUND   = 4'd9,
        CAUSE_ABSENT    = 4'd10
    } t_cause;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic scan_rd;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic addr_last;
        logic out_busy;
    } t_ctrl_sts;

endpackage

FILE: rtl/mibf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mibf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mibf_datapath.sv
// Datapath: request register, binding table scan, verdict and result register.
`timescale 1ns / 1ps

module mibf_datapath #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mibf_pkg::t_ctrl_cmd                  i_cmd,
    output mibf_pkg::t_ctrl_sts                  o_sts,
    input  logic [mibf_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic [mibf_pkg::REQ_W-1:0]           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [mibf_pkg::M_TDATA_W-1:0]       o_m_tdata
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    // Held request word.
    mibf_pkg::t_req                    r_req;
    logic [mibf_pkg::LEN_W-1:0]        r_len;
    logic [mibf_pkg::ETYPE_W-1:0]      r_etype;
    logic [mibf_pkg::IP_W-1:0]         r_src_ip;
    logic [mibf_pkg::PROTO_W-1:0]      r_proto;
    logic [mibf_pkg::IHL_W-1:0]        r_ihl;
    logic [mibf_pkg::MAC_W-1:0]        r_key;
    logic [mibf_pkg::IP_W-1:0]         r_bind_ip;

    // Scan state.
    logic [AW-1:0]                     r_addr;
    logic                              r_cmp_vld;
    logic [AW-1:0]                     r_cmp_idx;
    logic                              r_hit;
    logic [AW-1:0]                     r_hit_idx;
    logic [mibf_pkg::IP_W-1:0]         r_hit_ip;
    logic                              r_free;
    logic [AW-1:0]                     r_free_idx;

    // Result register.
    logic                              r_out_vld;
    logic                              r_out_drop;
    mibf_pkg::t_cause                  r_out_cause;

    logic [mibf_pkg::ENTRY_W-1:0]      rd_data;
    logic                              rd_valid;
    logic [mibf_pkg::MAC_W-1:0]        rd_mac;
    logic [mibf_pkg::IP_W-1:0]         rd_ip;

    logic                              upd_wr;
    logic [AW-1:0]                     upd_addr;
    logic [mibf_pkg::ENTRY_W-1:0]      upd_data;
    logic                              n_drop;
    mibf_pkg::t_cause                  n_cause;
    logic [mibf_pkg::LEN_W-1:0]        tcp_need;

    logic                              ram_wr_en;
    logic [AW-1:0]                     ram_wr_addr;
    logic [mibf_pkg::ENTRY_W-1:0]      ram_wr_data;

    assign rd_valid = rd_data[mibf_pkg::ENTRY_W-1];
    assign rd_mac   = rd_data[mibf_pkg::IP_W +: mibf_pkg::MAC_W];
    assign rd_ip    = rd_data[mibf_pkg::IP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= mibf_pkg::t_req'(i_s_tuser);
            r_len     <= i_s_tdata[15:0];
            r_etype   <= i_s_tdata[31:16];
            r_src_ip  <= i_s_tdata[111:80];
            r_proto   <= i_s_tdata[119:112];
            r_ihl     <= i_s_tdata[123:120];
            r_bind_ip <= i_s_tdata[203:172];
            // Checks look up the frame source, table operations their own key.
            if (mibf_pkg::t_req'(i_s_tuser) == mibf_pkg::REQ_CHECK) begin
                r_key <= i_s_tdata[79:32];
            end else begin
                r_key <= i_s_tdata[171:124];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_addr <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (i_cmd.clr_wr || i_cmd.scan_rd) begin
                    r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + AW'(1);
                end
                if (r_cmp_vld) begin
                    if (rd_valid && rd_mac == r_key && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (!rd_valid && !r_free) begin
                        r_free <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (r_cmp_vld && rd_valid && rd_mac == r_key && !r_hit) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_ip  <= rd_ip;
        end
        // The first free slot seen is the lowest one.
        if (r_cmp_vld && !rd_valid && !r_free) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    assign tcp_need = mibf_pkg::ETH_HDR_BYTES + mibf_pkg::TCP_HDR_BYTES
                    + {{(mibf_pkg::LEN_W - mibf_pkg::IHL_W - 2){1'b0}}, r_ihl, 2'b00};

    always_comb begin
        n_drop   = 1'b0;
        n_cause  = mibf_pkg::CAUSE_OK;
        upd_wr   = 1'b0;
        upd_addr = r_hit_idx;
        upd_data = {1'b1, r_key, r_bind_ip};
        unique case (r_req)
            mibf_pkg::REQ_CHECK: begin
                priority if (r_len < mibf_pkg::ETH_HDR_BYTES) begin
                    n_cause = mibf_pkg::CAUSE_SHORT_ETH;
                end else if (r_etype != mibf_pkg::ETHERTYPE_IPV4) begin
                    n_cause = mibf_pkg::CAUSE_NOT_IPV4;
                end else if (r_len < mibf_pkg::ETH_HDR_BYTES + mibf_pkg::IP_HDR_BYTES) begin
                    n_cause = mibf_pkg::CAUSE_SHORT_IP;
                end else if (!r_hit) begin
                    n_drop  = 1'b1;
                    n_cause = mibf_pkg::CAUSE_UNKNOWN;
                end else if (r_hit_ip != r_src_ip) begin
                    n_drop  = 1'b1;
                    n_cause = mibf_pkg::CAUSE_MISMATCH;
                end else if (r_proto == mibf_pkg::PROTO_TCP && tcp_need > r_len) begin
                    n_drop  = 1'b1;
                    n_cause = mibf_pkg::CAUSE_SHORT_TCP;
                end else begin
                    n_cause = mibf_pkg::CAUSE_OK;
                end
            end
            mibf_pkg::REQ_BIND: begin
                priority if (r_hit) begin
                    upd_wr  = 1'b1;
                    n_cause = mibf_pkg::CAUSE_BOUND;
                end else if (r_free) begin
                    upd_wr   = 1'b1;
                    upd_addr = r_free_idx;
                    n_cause  = mibf_pkg::CAUSE_BOUND;
                end else begin
                    n_cause = mibf_pkg::CAUSE_FULL;
                end
            end
            mibf_pkg::REQ_UNBIND: begin
                upd_data = '0;
                if (r_hit) begin
                    upd_wr  = 1'b1;
                    n_cause = mibf_pkg::CAUSE_UNBOUND;
                end else begin
                    n_cause = mibf_pkg::CAUSE_ABSENT;
                end
            end
            mibf_pkg::REQ_RSVD: begin
                n_cause = mibf_pkg::CAUSE_OK;
            end
            default: begin
                n_cause = mibf_pkg::CAUSE_OK;
            end
        endcase
    end

    // The clearing pass and the table update never overlap.
    assign ram_wr_en   = i_cmd.clr_wr || (i_cmd.finish && upd_wr);
    assign ram_wr_addr = i_cmd.clr_wr ? r_addr : upd_addr;
    assign ram_wr_data = i_cmd.clr_wr ? '0 : upd_data;

    mibf_ram #(
        .WIDTH (mibf_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (i_cmd.scan_rd),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_drop  <= n_drop;
            r_out_cause <= n_cause;
        end
    end

    assign o_sts.addr_last = (r_addr == LAST_ADDR);
    assign o_sts.out_busy  = r_out_vld;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out_cause, r_out_drop};

endmodule

FILE: rtl/mibf_ctrl.sv
// Controller: clearing pass, table scan sequencing and result hand-off.
`timescale 1ns / 1ps

module mibf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic                i_m_tready,
    input  mibf_pkg::t_ctrl_sts i_sts,
    output mibf_pkg::t_ctrl_cmd o_cmd
);

    mibf_pkg::t_state r_state;
    mibf_pkg::t_state n_state;
    logic             can_finish;

    // The result register frees up in the same cycle it is taken.
    assign can_finish = !i_sts.out_busy || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mibf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mibf_pkg::ST_CLEAR: begin
                if (i_sts.addr_last) begin
                    n_state = mibf_pkg::ST_IDLE;
                end
            end
            mibf_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = mibf_pkg::ST_SCAN;
                end
            end
            mibf_pkg::ST_SCAN: begin
                if (i_sts.addr_last) begin
                    n_state = mibf_pkg::ST_DRAIN;
                end
            end
            mibf_pkg::ST_DRAIN: begin
                n_state = mibf_pkg::ST_FINISH;
            end
            mibf_pkg::ST_FINISH: begin
                if (can_finish) begin
                    n_state = mibf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mibf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            mibf_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            mibf_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            mibf_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            mibf_pkg::ST_DRAIN: begin
                o_cmd = '0;
            end
            mibf_pkg::ST_FINISH: begin
                o_cmd.finish = can_finish;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/mac_ip_binding_filter.sv
// Top level of the MAC/IP binding filter.
`timescale 1ns / 1ps

// The block keeps up to TABLE_ENTRIES bindings of a trusted source MAC to its IPv4
// address in a single RAM and answers every word with one result word: a pass or
// drop verdict with its cause for a packet check, or the outcome of a bind or
// unbind. Each word walks the whole table, one entry per cycle through the RAM
// read port, and the next word is not taken until its result is registered.
// After reset the block clears the table in a pass over every entry, during which
// no word is accepted. A finished result waits in an output register while the
// next word is taken in and scanned.
module mac_ip_binding_filter #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // frame_len, ethertype, src_mac, src_ip, ip_protocol, header_words,
    // bind_mac, bind_ip, then zero fill
    input  logic [mibf_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // req_type
    input  logic [mibf_pkg::REQ_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // drop, cause, then zero fill
    output logic [mibf_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    mibf_pkg::t_ctrl_cmd cmd;
    mibf_pkg::t_ctrl_sts sts;

    mibf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mibf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: rtl/mibf_checker.sv
// Port-level checks of the MAC/IP binding filter and their binding to the top level.
`timescale 1ns / 1ps

module mibf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [mibf_pkg::M_TDATA_W-1:0] o_m_tdata
);

    logic [mibf_pkg::CAUSE_W-1:0] cause;
    logic                         drop;

    assign drop  = o_m_tdata[0];
    assign cause = o_m_tdata[4:1];

    // Reset empties the result register and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("ready or result shown right after reset");

    // A taken word is scanned before the next one is accepted.
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after a word was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    // Only an unknown source, an IP mismatch or a short TCP header drops a frame.
    a_drop_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && drop |->
            cause == mibf_pkg::CAUSE_UNKNOWN || cause == mibf_pkg::CAUSE_MISMATCH ||
            cause == mibf_pkg::CAUSE_SHORT_TCP)
        else $error("drop with a passing cause");

    a_cause_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (cause == mibf_pkg::CAUSE_UNKNOWN ||
            cause == mibf_pkg::CAUSE_MISMATCH || cause == mibf_pkg::CAUSE_SHORT_TCP)
            |-> drop)
        else $error("drop cause without drop");

endmodule

bind mac_ip_binding_filter mibf_checker u_mibf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
